### sv/vad_pkg.sv
// Package for the vertex attribute dedup block.
// Holds table sizes, field widths, status and op codes, FSM state type and
// the command/status structs between controller and datapath. No dependencies.
package vad_pkg;

    // Table geometry
    localparam int POSITION_ROWS = 4096;
    localparam int SLOTS_PER_ROW = 4;

    // Field widths
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    localparam int ST_W    = 2;
    localparam int ENTRY_W = 3 * IDX_W;

    // Derived storage widths
    localparam int ROW_W      = $clog2(POSITION_ROWS);
    localparam int FILL_W     = $clog2(SLOTS_PER_ROW + 1);
    localparam int SLOT_DEPTH = POSITION_ROWS * SLOTS_PER_ROW;
    localparam int SLOT_AW    = $clog2(SLOT_DEPTH);

    // Output vertex counter limit
    localparam logic [CNT_W-1:0] VCOUNT_LIMIT = CNT_W'(4096);

    typedef enum logic [0:0] {
        OP_RESOLVE = 1'b0,
        OP_CLEAR   = 1'b1
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_MATCH   = 2'd0,
        ST_INSERT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_EXHAUST = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_SCAN,
        S_WRITE,
        S_CLEAR,
        S_DONE
    } t_state;

    // Which result the datapath stages
    typedef enum logic [2:0] {
        RES_CLEAR,
        RES_RANGE,
        RES_MATCH,
        RES_FULL,
        RES_EXHAUST,
        RES_INSERT
    } t_res_sel;

    // Controller to datapath
    typedef struct packed {
        logic     capture;
        logic     fill_rd;
        logic     slot_next;
        logic     slot_wr;
        logic     sweep;
        logic     count_clr;
        logic     set_res;
        t_res_sel res_sel;
        logic     load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic op_clear;
        logic range_bad;
        logic slot_hit;
        logic more_slots;
        logic row_full;
        logic count_done;
        logic sweep_last;
        logic out_free;
    } t_stat;

endpackage

### sv/vad_intf.sv
// Handshake interfaces for the vertex attribute dedup block.
// vad_in_if carries index triples, vad_out_if carries results. Uses vad_pkg.
interface vad_in_if
    import vad_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             op;
    logic [IDX_W-1:0] vert_index;
    logic [IDX_W-1:0] tex_index;
    logic [IDX_W-1:0] norm_index;

    modport source (output valid, op, vert_index, tex_index, norm_index, input ready);
    modport sink   (input valid, op, vert_index, tex_index, norm_index, output ready);
endinterface

interface vad_out_if
    import vad_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] new_index;
    logic [IDX_W-1:0] first_index;
    logic             link_made;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] vertex_count;

    modport source (output valid, new_index, first_index, link_made, status, vertex_count,
                    input ready);
    modport sink   (input valid, new_index, first_index, link_made, status, vertex_count,
                    output ready);
endinterface

### sv/vertex_attribute_dedup.sv
// Top level of the vertex attribute dedup block.
// Joins vad_ctrl and vad_datapath; depends on vad_pkg and vad_intf.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------------
//  i_in     | in  | valid / ready | op, vert_index, tex_index, norm_index
//  o_out    | out | valid / ready | new_index, first_index, link_made, status,
//           |     |               | vertex_count
//
// A resolve reads the fill count and slot 0 together, then scans the row one slot per
// cycle (one read port) and, on a miss with room left, writes the new entry; once its
// result moves to the output register the block returns to idle and takes the next item.
// A clear, and the pass after reset, sweep the fill-count memory one row per
// cycle over all POSITION_ROWS rows, with i_in.ready low throughout.
// Reset is synchronous, active low. The next item is accepted while a result waits;
// the block stalls only when a second result is ready before the first is taken.
module vertex_attribute_dedup
    import vad_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    vad_in_if.sink    i_in,
    vad_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    vad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vad_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_in.op),
        .i_vert_index   (i_in.vert_index),
        .i_tex_index    (i_in.tex_index),
        .i_norm_index   (i_in.norm_index),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_new_index    (o_out.new_index),
        .o_first_index  (o_out.first_index),
        .o_link_made    (o_out.link_made),
        .o_status       (o_out.status),
        .o_vertex_count (o_out.vertex_count)
    );

endmodule

### sv/vad_ctrl.sv
// Controller FSM for the vertex attribute dedup block.
// Sequences fill read, slot scan, insert, clearing sweep and result hand-off.
// Uses vad_pkg.
module vad_ctrl
    import vad_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    // State register; reset starts with a sweep of the fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_START;
            end
            S_START: begin
                if (i_stat.op_clear)       n_state = S_CLEAR;
                else if (i_stat.range_bad) n_state = S_DONE;
                else                       n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.slot_hit)        n_state = S_DONE;
                else if (i_stat.more_slots) n_state = S_SCAN;
                else if (i_stat.row_full)   n_state = S_DONE;
                else if (i_stat.count_done) n_state = S_DONE;
                else                        n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_CLEAR: begin
                if (i_stat.sweep_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.res_sel = RES_CLEAR;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep     = 1'b1;
                o_cmd.count_clr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_START: begin
                if (i_stat.op_clear) begin
                    o_cmd.count_clr = 1'b1;
                end else if (i_stat.range_bad) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RES_RANGE;
                end else begin
                    o_cmd.fill_rd = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_stat.slot_hit) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RES_MATCH;
                end else if (i_stat.more_slots) begin
                    o_cmd.slot_next = 1'b1;
                end else if (i_stat.row_full) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RES_FULL;
                end else if (i_stat.count_done) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RES_EXHAUST;
                end
            end
            S_WRITE: begin
                o_cmd.slot_wr = 1'b1;
                o_cmd.set_res = 1'b1;
                o_cmd.res_sel = RES_INSERT;
            end
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RES_CLEAR;
                end
            end
            S_DONE: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### sv/vad_datapath.sv
// Datapath for the vertex attribute dedup block: fill count memory,
// slot memory, vertex counter, result staging and output register.
// Uses vad_pkg; driven by vad_ctrl through t_cmd / t_stat.
module vad_datapath
    import vad_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic             i_op,
    input  logic [IDX_W-1:0] i_vert_index,
    input  logic [IDX_W-1:0] i_tex_index,
    input  logic [IDX_W-1:0] i_norm_index,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [IDX_W-1:0] o_new_index,
    output logic [IDX_W-1:0] o_first_index,
    output logic             o_link_made,
    output logic [ST_W-1:0]  o_status,
    output logic [CNT_W-1:0] o_vertex_count
);

    // Captured item
    logic             r_op;
    logic             r_range_bad;
    logic [ROW_W-1:0] r_row;
    logic [IDX_W-1:0] r_tex;
    logic [IDX_W-1:0] r_norm;

    // Scan state
    logic [FILL_W-1:0]  r_fill_q;
    logic [FILL_W-1:0]  r_slot;
    logic [ENTRY_W-1:0] r_slot_q;
    logic [IDX_W-1:0]   r_first;

    // Counters
    logic [CNT_W-1:0] r_count;
    logic [ROW_W-1:0] r_sweep;

    // Staged result
    logic [IDX_W-1:0] r_res_new;
    logic [IDX_W-1:0] r_res_first;
    logic             r_res_link;
    logic [ST_W-1:0]  r_res_status;
    logic [CNT_W-1:0] r_res_count;

    // Output register
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_new;
    logic [IDX_W-1:0] r_out_first;
    logic             r_out_link;
    logic [ST_W-1:0]  r_out_status;
    logic [CNT_W-1:0] r_out_count;

    // Memories
    logic [FILL_W-1:0]  fill_mem [POSITION_ROWS];
    logic [ENTRY_W-1:0] slot_mem [SLOT_DEPTH];

    logic [FILL_W-1:0]  fill_eff;
    logic [FILL_W-1:0]  slot_inc;
    logic [FILL_W-1:0]  rd_slot;
    logic [SLOT_AW-1:0] rd_addr;
    logic [SLOT_AW-1:0] wr_addr;
    logic [IDX_W-1:0]   q_tex;
    logic [IDX_W-1:0]   q_norm;
    logic [IDX_W-1:0]   q_idx;
    logic [IDX_W-1:0]   first_cur;
    logic [IDX_W-1:0]   new_idx;

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_op;
            r_range_bad <= (32'(i_vert_index) >= POSITION_ROWS);
            r_row       <= ROW_W'(i_vert_index);
            r_tex       <= i_tex_index;
            r_norm      <= i_norm_index;
        end
    end

    // Fill count clamp and slot addressing
    assign fill_eff = (r_fill_q > FILL_W'(SLOTS_PER_ROW)) ? FILL_W'(SLOTS_PER_ROW) : r_fill_q;
    assign slot_inc = FILL_W'(r_slot + 1'b1);
    assign rd_slot  = i_cmd.fill_rd ? '0 : slot_inc;
    assign rd_addr  = SLOT_AW'(int'(r_row) * SLOTS_PER_ROW + int'(rd_slot));
    assign wr_addr  = SLOT_AW'(int'(r_row) * SLOTS_PER_ROW + int'(fill_eff));
    assign new_idx  = r_count[IDX_W-1:0];

    // Fill count memory: sweep or insert write, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            fill_mem[r_sweep] <= '0;
        end else if (i_cmd.slot_wr) begin
            fill_mem[r_row] <= FILL_W'(fill_eff + 1'b1);
        end
        if (i_cmd.fill_rd) begin
            r_fill_q <= fill_mem[r_row];
        end
    end

    // Slot memory: entry is {tex, norm, index}, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.slot_wr) begin
            slot_mem[wr_addr] <= {r_tex, r_norm, new_idx};
        end
        if (i_cmd.fill_rd || i_cmd.slot_next) begin
            r_slot_q <= slot_mem[rd_addr];
        end
    end

    assign q_tex  = r_slot_q[3*IDX_W-1:2*IDX_W];
    assign q_norm = r_slot_q[2*IDX_W-1:IDX_W];
    assign q_idx  = r_slot_q[IDX_W-1:0];

    // First slot index: taken from slot 0 data, held once the scan moves on
    assign first_cur = (r_slot != '0) ? r_first : ((fill_eff != '0) ? q_idx : '0);

    // Slot pointer and first index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_cmd.fill_rd) begin
            r_slot <= '0;
        end else if (i_cmd.slot_next) begin
            r_slot <= slot_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.slot_next) begin
            r_first <= first_cur;
        end
    end

    // Vertex counter and sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sweep <= '0;
        end else begin
            if (i_cmd.count_clr) begin
                r_count <= '0;
            end else if (i_cmd.slot_wr) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.sweep) begin
                r_sweep <= o_stat.sweep_last ? '0 : r_sweep + 1'b1;
            end
        end
    end

    // Status to controller
    always_comb begin
        o_stat.op_clear   = (r_op == OP_CLEAR);
        o_stat.range_bad  = r_range_bad;
        o_stat.slot_hit   = (r_slot < fill_eff) && (q_tex == r_tex) && (q_norm == r_norm);
        o_stat.more_slots = (slot_inc < fill_eff);
        o_stat.row_full   = (fill_eff >= FILL_W'(SLOTS_PER_ROW));
        o_stat.count_done = (r_count >= VCOUNT_LIMIT);
        o_stat.sweep_last = (r_sweep == ROW_W'(POSITION_ROWS - 1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // Result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            unique case (i_cmd.res_sel)
                RES_CLEAR: begin
                    r_res_new    <= '0;
                    r_res_first  <= '0;
                    r_res_link   <= 1'b0;
                    r_res_status <= ST_MATCH;
                    r_res_count  <= '0;
                end
                RES_RANGE: begin
                    r_res_new    <= '0;
                    r_res_first  <= '0;
                    r_res_link   <= 1'b0;
                    r_res_status <= ST_FULL;
                    r_res_count  <= r_count;
                end
                RES_MATCH: begin
                    r_res_new    <= q_idx;
                    r_res_first  <= first_cur;
                    r_res_link   <= 1'b0;
                    r_res_status <= ST_MATCH;
                    r_res_count  <= r_count;
                end
                RES_FULL: begin
                    r_res_new    <= '0;
                    r_res_first  <= first_cur;
                    r_res_link   <= 1'b0;
                    r_res_status <= ST_FULL;
                    r_res_count  <= r_count;
                end
                RES_EXHAUST: begin
                    r_res_new    <= '0;
                    r_res_first  <= first_cur;
                    r_res_link   <= 1'b0;
                    r_res_status <= ST_EXHAUST;
                    r_res_count  <= r_count;
                end
                RES_INSERT: begin
                    r_res_new    <= new_idx;
                    r_res_first  <= (fill_eff == '0) ? new_idx : first_cur;
                    r_res_link   <= (fill_eff != '0);
                    r_res_status <= ST_INSERT;
                    r_res_count  <= r_count + 1'b1;
                end
                default: begin
                    r_res_new    <= '0;
                    r_res_first  <= '0;
                    r_res_link   <= 1'b0;
                    r_res_status <= ST_MATCH;
                    r_res_count  <= '0;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_new    <= r_res_new;
            r_out_first  <= r_res_first;
            r_out_link   <= r_res_link;
            r_out_status <= r_res_status;
            r_out_count  <= r_res_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_new_index    = r_out_new;
    assign o_first_index  = r_out_first;
    assign o_link_made    = r_out_link;
    assign o_status       = r_out_status;
    assign o_vertex_count = r_out_count;

endmodule

### sv/vad_checker.sv
// Port-level checker for the vertex attribute dedup block, bound to the top.
// Tracks items in flight and checks result consistency. Uses vad_pkg.
module vad_checker
    import vad_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [IDX_W-1:0] i_new_index,
    input logic             i_link_made,
    input logic [ST_W-1:0]  i_status,
    input logic [CNT_W-1:0] i_vertex_count
);

    logic [1:0] r_pend;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Items accepted whose result is not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    // At most one item in work plus one result waiting
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 2'd2)
        else $error("more than two items in flight");

    // No result without an accepted item
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("result without an accepted item");

    // A split link only comes with an insert
    a_link_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_link_made) |-> i_status == ST_INSERT)
        else $error("link reported without insert");

    // Error results carry index zero and no link
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_FULL || i_status == ST_EXHAUST))
            |-> (i_new_index == '0 && !i_link_made))
        else $error("error result with nonzero index or link");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_vertex_count)
            && $stable(i_status) && $stable(i_new_index)))
        else $error("stalled result changed");

endmodule

bind vertex_attribute_dedup vad_checker u_vad_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_new_index    (o_out.new_index),
    .i_link_made    (o_out.link_made),
    .i_status       (o_out.status),
    .i_vertex_count (o_out.vertex_count)
);
